@@ rtl/core/assert_macros.svh @@
// assertion helpers for the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/core/spd_pkg.sv @@
package spd_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FIRST_PRE  = 3'd0;
    localparam t_cfg_idx CFG_SECOND_PRE = 3'd1;
    localparam t_cfg_idx CFG_MIN_LEN    = 3'd2;
    localparam t_cfg_idx CFG_MAX_LEN    = 3'd3;
    localparam t_cfg_idx CFG_NET_ID     = 3'd4;

    localparam logic [7:0] RST_FIRST_PRE  = 8'd0;
    localparam logic [7:0] RST_SECOND_PRE = 8'd0;
    localparam logic [7:0] RST_MIN_LEN    = 8'd3;
    localparam logic [7:0] RST_MAX_LEN    = 8'd255;
    localparam logic [7:0] RST_NET_ID     = 8'd0;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_PRE2  = 3'd1,
        PH_LEN   = 3'd2,
        PH_ADDR  = 3'd3,
        PH_NETID = 3'd4,
        PH_DATA  = 3'd5,
        PH_SUMHI = 3'd6,
        PH_SUMLO = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_PREAMBLE = 3'd1,
        ERR_LENGTH   = 3'd2,
        ERR_NETID    = 3'd3,
        ERR_CHECKSUM = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] first_pre;
        logic [7:0] second_pre;
        logic [7:0] min_len;
        logic [7:0] max_len;
        logic [7:0] net_id;
    } t_cfg;

    typedef struct packed {
        logic       byte_stored;
        logic [7:0] stored_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        logic       frame_good;
        t_err       error_code;
    } t_result;

endpackage

@@ rtl/core/spd_cfg_regs.sv @@
module spd_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  spd_pkg::t_cfg_idx i_index,
    input  logic [7:0]        i_data,
    output spd_pkg::t_cfg     o_cfg
);
    import spd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_pre  <= RST_FIRST_PRE;
            r_cfg.second_pre <= RST_SECOND_PRE;
            r_cfg.min_len    <= RST_MIN_LEN;
            r_cfg.max_len    <= RST_MAX_LEN;
            r_cfg.net_id     <= RST_NET_ID;
        end else if (i_we) begin
            unique case (i_index)
                CFG_FIRST_PRE:  r_cfg.first_pre  <= i_data;
                CFG_SECOND_PRE: r_cfg.second_pre <= i_data;
                CFG_MIN_LEN:    r_cfg.min_len    <= i_data;
                CFG_MAX_LEN:    r_cfg.max_len    <= i_data;
                CFG_NET_ID:     r_cfg.net_id     <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/spd_core.sv @@
module spd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  spd_pkg::t_cfg    i_cfg,
    output spd_pkg::t_result o_res
);
    import spd_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [7:0]  r_count,    n_count;
    logic [7:0]  r_len,      n_len;
    logic [15:0] r_sum,      n_sum;
    logic [7:0]  r_sum_hi,   n_sum_hi;
    t_result     res;
    logic        store;
    logic [7:0]  cnt_base;
    logic [15:0] sum_base;
    logic [7:0]  cnt_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_count  <= 8'd0;
            r_len    <= 8'd0;
            r_sum    <= 16'd0;
            r_sum_hi <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_sum_hi <= n_sum_hi;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_sum_hi = r_sum_hi;
        store    = 1'b0;
        cnt_base = r_count;
        sum_base = r_sum;
        res      = '0;
        res.error_code = ERR_NONE;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.first_pre) begin
                    n_phase = PH_PRE2;
                end
            end
            PH_PRE2: begin
                if (i_byte == i_cfg.second_pre) begin
                    n_phase  = PH_LEN;
                    sum_base = 16'd0;
                    n_sum_hi = 8'd0;
                end else begin
                    n_phase        = PH_HUNT;
                    res.error_code = ERR_PREAMBLE;
                end
            end
            PH_LEN: begin
                if (i_byte <= i_cfg.max_len && i_byte >= i_cfg.min_len) begin
                    n_phase  = PH_ADDR;
                    cnt_base = 8'd0;
                    sum_base = 16'd0;
                    n_len    = i_byte;
                    store    = 1'b1;
                end else begin
                    n_phase        = PH_HUNT;
                    res.error_code = ERR_LENGTH;
                end
            end
            PH_ADDR: begin
                n_phase = PH_NETID;
                store   = 1'b1;
            end
            PH_NETID: begin
                if (i_byte == i_cfg.net_id) begin
                    n_phase = PH_DATA;
                    store   = 1'b1;
                end else begin
                    n_phase        = PH_HUNT;
                    res.error_code = ERR_NETID;
                end
            end
            PH_DATA: begin
                store = (r_count < r_len);
                // count after this byte reaches the length
                if (!store || (r_count + 8'd1) >= r_len) begin
                    n_phase = PH_SUMHI;
                end
            end
            PH_SUMHI: begin
                n_sum_hi = i_byte;
                n_phase  = PH_SUMLO;
            end
            PH_SUMLO: begin
                n_phase       = PH_HUNT;
                res.frame_end = 1'b1;
                if ({r_sum_hi, i_byte} == r_sum) begin
                    res.frame_good = 1'b1;
                end else begin
                    res.error_code = ERR_CHECKSUM;
                end
            end
            default: ;
        endcase

        cnt_inc = cnt_base + 8'd1;
        n_count = store ? cnt_inc : cnt_base;
        n_sum   = store ? (sum_base + {8'd0, i_byte}) : sum_base;
        if (store) begin
            res.byte_stored = 1'b1;
            res.stored_byte = i_byte;
            res.byte_index  = cnt_base;
        end
    end

    assign o_res = res;

endmodule

@@ rtl/core/serial_packet_deframer.sv @@
// Serial packet deframer: recovers frames of the form preamble, preamble, length,
// address, network id, data, 16-bit big-endian sum from a byte stream. Every
// request yields exactly one result: stored bytes carry their frame index, the
// checksum low byte flags frame end and checksum status, and header faults
// return an error code. Throughput is one byte per clock while the output side
// accepts results; a byte is captured in the input register, then the phase
// update with a 16-bit sum add writes its result into the output register,
// which presents it until it is accepted. Configuration is
// written through i_cfg_we / i_cfg_index / i_cfg_data and should change only
// while no request is in flight.
`include "assert_macros.svh"

module serial_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_byte_stored,
    output logic [7:0] o_stored_byte,
    output logic [7:0] o_byte_index,
    output logic       o_frame_end,
    output logic       o_frame_good,
    output logic [2:0] o_error_code
);
    import spd_pkg::*;

    t_cfg       cfg;
    t_result    res;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       adv;

    spd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    spd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && adv),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_stored = r_out.byte_stored;
    assign o_stored_byte = r_out.stored_byte;
    assign o_byte_index  = r_out.byte_index;
    assign o_frame_end   = r_out.frame_end;
    assign o_frame_good  = r_out.frame_good;
    assign o_error_code  = r_out.error_code;

    `ASSERT_IMPLY(a_good_ends, i_clk, i_rst_n, o_out_valid && o_frame_good, o_frame_end && o_error_code == ERR_NONE)
    `ASSERT_NEVER(a_store_no_err, i_clk, i_rst_n, o_out_valid && o_byte_stored && o_error_code != ERR_NONE)
    `ASSERT_NEVER(a_end_no_store, i_clk, i_rst_n, o_out_valid && o_frame_end && o_byte_stored)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import spd_pkg::*;

    class frame_scoreboard;
        t_cfg       cfg;
        t_phase     phase_q;
        logic [7:0] count_q;
        logic [7:0] len_q;
        logic [15:0] sum_q;
        logic [7:0] sum_hi_q;
        t_result    expected_results[$];
        int         mismatches;

        function new();
            cfg = '{RST_FIRST_PRE, RST_SECOND_PRE, RST_MIN_LEN, RST_MAX_LEN, RST_NET_ID};
            phase_q = PH_HUNT;
            count_q = '0;
            len_q = '0;
            sum_q = '0;
            sum_hi_q = '0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [7:0] v);
            case (idx)
                CFG_FIRST_PRE:  cfg.first_pre = v;
                CFG_SECOND_PRE: cfg.second_pre = v;
                CFG_MIN_LEN:    cfg.min_len = v;
                CFG_MAX_LEN:    cfg.max_len = v;
                CFG_NET_ID:     cfg.net_id = v;
                default: ;
            endcase
        endfunction

        function void keep_byte(logic [7:0] b, inout t_result r);
            r.byte_stored = 1'b1;
            r.stored_byte = b;
            r.byte_index = count_q;
            count_q = count_q + 8'd1;
            sum_q = sum_q + {8'd0, b};
        endfunction

        function t_result deframe_byte(logic [7:0] b);
            t_result r;
            r = '0;
            r.error_code = ERR_NONE;
            case (phase_q)
                PH_HUNT: begin
                    if (b == cfg.first_pre) phase_q = PH_PRE2;
                end
                PH_PRE2: begin
                    if (b == cfg.second_pre) begin
                        phase_q = PH_LEN;
                        sum_q = '0;
                        sum_hi_q = '0;
                    end else begin
                        phase_q = PH_HUNT;
                        r.error_code = ERR_PREAMBLE;
                    end
                end
                PH_LEN: begin
                    if (b <= cfg.max_len && b >= cfg.min_len) begin
                        phase_q = PH_ADDR;
                        count_q = '0;
                        sum_q = '0;
                        len_q = b;
                        keep_byte(b, r);
                    end else begin
                        phase_q = PH_HUNT;
                        r.error_code = ERR_LENGTH;
                    end
                end
                PH_ADDR: begin
                    phase_q = PH_NETID;
                    keep_byte(b, r);
                end
                PH_NETID: begin
                    if (b == cfg.net_id) begin
                        phase_q = PH_DATA;
                        keep_byte(b, r);
                    end else begin
                        phase_q = PH_HUNT;
                        r.error_code = ERR_NETID;
                    end
                end
                PH_DATA: begin
                    if (count_q < len_q) keep_byte(b, r);
                    if (count_q >= len_q) phase_q = PH_SUMHI;
                end
                PH_SUMHI: begin
                    sum_hi_q = b;
                    phase_q = PH_SUMLO;
                end
                default: begin
                    phase_q = PH_HUNT;
                    r.frame_end = 1'b1;
                    if ({sum_hi_q, b} == sum_q) r.frame_good = 1'b1;
                    else r.error_code = ERR_CHECKSUM;
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [7:0] b);
            expected_results.push_back(deframe_byte(b));
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_results.size() == 0) begin
                $error("result with no request pending, stored_byte %0h", got.stored_byte);
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            compare_field("byte_stored", exp.byte_stored, got.byte_stored);
            compare_field("stored_byte", exp.stored_byte, got.stored_byte);
            compare_field("byte_index", exp.byte_index, got.byte_index);
            compare_field("frame_end", exp.frame_end, got.frame_end);
            compare_field("frame_good", exp.frame_good, got.frame_good);
            compare_field("error_code", exp.error_code, got.error_code);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    typedef enum int {FAULT_NONE, FAULT_PRE2, FAULT_LEN, FAULT_NET, FAULT_SUM} t_fault;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_rx_byte = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_byte_stored;
    logic [7:0] o_stored_byte;
    logic [7:0] o_byte_index;
    logic       o_frame_end;
    logic       o_frame_good;
    logic [2:0] o_error_code;

    frame_scoreboard sb;
    t_cfg            cur_cfg;
    logic [7:0]      tx_q[$];
    int              bytes_sent = 0;
    bit              no_idle = 1'b0;
    bit              long_hold = 1'b0;

    serial_packet_deframer uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(b);
        bytes_sent++;
    endtask

    task automatic flush_tx();
        while (tx_q.size() != 0) send_byte(tx_q.pop_front());
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        sb.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] fp, input logic [7:0] sp,
                              input logic [7:0] mn, input logic [7:0] mx,
                              input logic [7:0] net);
        write_reg(CFG_FIRST_PRE, fp);
        write_reg(CFG_SECOND_PRE, sp);
        write_reg(CFG_MIN_LEN, mn);
        write_reg(CFG_MAX_LEN, mx);
        write_reg(CFG_NET_ID, net);
        i_cfg_we <= 1'b0;
        cur_cfg = '{fp, sp, mn, mx, net};
    endtask

    task automatic build_frame(input t_fault fault);
        logic [7:0]  frame_len;
        logic [7:0]  addr;
        logic [7:0]  d;
        logic [15:0] sum;
        int          lo;
        int          hi;
        lo = cur_cfg.min_len;
        hi = cur_cfg.max_len;
        tx_q.push_back(cur_cfg.first_pre);
        if (fault == FAULT_PRE2) begin
            tx_q.push_back(cur_cfg.second_pre ^ 8'($urandom_range(1, 255)));
            return;
        end
        tx_q.push_back(cur_cfg.second_pre);
        if (fault == FAULT_LEN) begin
            if (lo > hi) begin
                tx_q.push_back(8'($urandom_range(0, 255)));
                return;
            end
            if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 0)) begin
                tx_q.push_back(8'($urandom_range(0, lo - 1)));
                return;
            end
            if (hi < 255) begin
                tx_q.push_back(8'($urandom_range(hi + 1, 255)));
                return;
            end
            fault = FAULT_NET;
        end
        if (lo > hi) frame_len = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 39) == 0) frame_len = 8'($urandom_range(lo, hi));
        else frame_len = 8'($urandom_range(lo, (hi < lo + 12) ? hi : lo + 12));
        addr = 8'($urandom_range(0, 255));
        tx_q.push_back(frame_len);
        tx_q.push_back(addr);
        sum = {8'd0, frame_len} + {8'd0, addr};
        if (fault == FAULT_NET) begin
            tx_q.push_back(cur_cfg.net_id ^ 8'($urandom_range(1, 255)));
            return;
        end
        tx_q.push_back(cur_cfg.net_id);
        sum = sum + {8'd0, cur_cfg.net_id};
        if (frame_len > 8'd3) begin
            for (int n = 3; n < frame_len; n++) begin
                d = 8'($urandom_range(0, 255));
                tx_q.push_back(d);
                sum = sum + {8'd0, d};
            end
        end else begin
            // dropped byte before the checksum
            tx_q.push_back(8'($urandom_range(0, 255)));
        end
        if (fault == FAULT_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
        tx_q.push_back(sum[15:8]);
        tx_q.push_back(sum[7:0]);
    endtask

    task automatic run_phase(input int target);
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) build_frame(FAULT_NONE);
            else if (r < 88) build_frame(t_fault'($urandom_range(FAULT_PRE2, FAULT_SUM)));
            else repeat ($urandom_range(1, 5)) tx_q.push_back(8'($urandom_range(0, 255)));
            flush_tx();
        end
    endtask

    initial begin : main
        logic [7:0] mn;
        sb = new();
        cur_cfg = sb.cfg;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hunt miss, empty frame, length, preamble, net id and checksum errors
        tx_q = '{8'h55,
                 8'h00, 8'h00, 8'h03, 8'hFF, 8'h00, 8'hAA, 8'h01, 8'h02,
                 8'h00, 8'h00, 8'h02,
                 8'h00, 8'hFF,
                 8'h00, 8'h00, 8'h04, 8'h12, 8'h05,
                 8'h00, 8'h00, 8'h04, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h00};
        flush_tx();

        // lengths under the header size
        wait_drained();
        set_config(8'hFF, 8'hFF, 8'd0, 8'd255, 8'hFF);
        run_phase(60);

        wait_drained();
        set_config(8'hA5, 8'h5A, 8'd3, 8'd3, 8'h00);
        run_phase(50);

        // back to back requests while the output side holds off
        wait_drained();
        mn = 8'($urandom_range(0, 10));
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), mn,
                   mn + 8'($urandom_range(0, 20)), 8'($urandom_range(0, 255)));
        no_idle = 1'b1;
        long_hold = 1'b1;
        run_phase(80);
        no_idle = 1'b0;

        // longest frame
        wait_drained();
        set_config(8'h00, 8'h00, 8'd255, 8'd255, 8'($urandom_range(0, 255)));
        build_frame(FAULT_NONE);
        flush_tx();

        // empty length window
        wait_drained();
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255, 8'd0,
                   8'($urandom_range(0, 255)));
        run_phase(30);

        wait_drained();
        mn = 8'($urandom_range(0, 20));
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), mn,
                   8'($urandom_range(mn, 255)), 8'($urandom_range(0, 255)));
        run_phase(90);

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : receiver
        t_result got;
        int      stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.byte_stored = o_byte_stored;
                got.stored_byte = o_stored_byte;
                got.byte_index = o_byte_index;
                got.frame_end = o_frame_end;
                got.frame_good = o_frame_good;
                got.error_code = t_err'(o_error_code);
                sb.check_result(got);
            end
            if (long_hold) begin
                long_hold = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (no_idle || $urandom_range(0, 99) < 75) begin
                i_out_ready <= 1'b1;
            end else begin
                stall = pick_gap();
                i_out_ready <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

@@ serial_packet_deframer.f @@
+incdir+rtl/core
rtl/core/spd_pkg.sv
rtl/core/spd_cfg_regs.sv
rtl/core/spd_core.sv
rtl/core/serial_packet_deframer.sv
verif/tb.sv
